/* hw/rtl/fifo_queue_with_search_macros.svh */
// ------------------------------------------------------------------------
// FIFO queue with search - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication.
`define FQS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fifo queue check failed");

// Next-cycle implication.
`define FQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fifo queue check failed");

`endif

/* hw/rtl/fqs_pkg.sv */
// ------------------------------------------------------------------------
// FIFO queue with search - package
// Field widths, default sizes, opcode and status codes, cell control.
// ------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int ITEM_BITS     = 32;
  localparam int OPCODE_BITS   = 2;
  localparam int STATUS_BITS   = 2;
  localparam int OCC_BITS      = 5;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/fqs_in_if.sv */
// ------------------------------------------------------------------------
// FIFO queue with search - request channel
// Valid/ready channel carrying one opcode and one word per item.
// ------------------------------------------------------------------------
`default_nettype none

interface fqs_in_if import fqs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OPCODE_BITS-1:0] opcode;
  logic [ITEM_BITS-1:0]   item_word;

  modport source (output valid, opcode, item_word, input ready);
  modport sink   (input valid, opcode, item_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fqs_out_if.sv */
// ------------------------------------------------------------------------
// FIFO queue with search - result channel
// Valid/ready channel carrying one result item per request.
// ------------------------------------------------------------------------
`default_nettype none

interface fqs_out_if import fqs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ITEM_BITS-1:0]   data_out;
  logic                   found;
  logic [STATUS_BITS-1:0] status;
  logic                   is_empty;
  logic                   is_full;
  logic [OCC_BITS-1:0]    occupancy;

  modport source (output valid, data_out, found, status, is_empty, is_full, occupancy,
                  input ready);
  modport sink   (input valid, data_out, found, status, is_empty, is_full, occupancy,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/fifo_queue_with_search.sv */
// ------------------------------------------------------------------------
// FIFO queue with search - top level
// Shift-register queue of DEPTH words with a parallel membership search.
// ------------------------------------------------------------------------
// The queue is a row of DEPTH cells with the oldest word always in the first
// cell: a dequeue shifts every cell one place toward the head, an enqueue
// fills the first empty cell, and a search compares all occupied cells at
// once. Every request yields one result, registered in the cycle after the
// request is taken; the block takes one request per cycle as long as the
// result register is free or being drained, so the output register alone
// sets the rate. No clearing pass follows reset.
`default_nettype none

module fifo_queue_with_search import fqs_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  fqs_in_if.sink     req,
  fqs_out_if.source  rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [DEPTH-1:0]             valid_q;
  logic [DEPTH-1:0]             match;
  logic [WORD_BITS-1:0]         word_q [DEPTH];
  logic [WORD_BITS-1:0]         word_in;
  logic [WORD_BITS+ITEM_BITS-1:0] in_ext;
  logic [WORD_BITS+ITEM_BITS-1:0] out_ext;
  logic [CW+OCC_BITS-1:0]       occ_ext;
  logic [WORD_BITS-1:0]         data;
  logic                         hit;
  status_t                      status;
  cell_ctl_t                    ctl;
  cell_ctl_t                    cell_ctl;
  logic                         accept;
  logic                         full;
  logic                         empty;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign in_ext  = {{WORD_BITS{1'b0}}, req.item_word};
  assign word_in = in_ext[WORD_BITS-1:0];

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctl        = '0;
    count_next = count;
    data       = '0;
    hit        = 1'b0;
    status     = ST_OK;
    case (opcode_t'(req.opcode))
      OP_ENQ: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.enq    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.deq    = 1'b1;
          data       = word_q[0];
          count_next = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        hit = |match;
      end
      default: begin
      end
    endcase
  end

  assign cell_ctl = accept ? ctl : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 prev_valid;
    logic                 next_valid;
    logic [WORD_BITS-1:0] next_word;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_word  = '0;
    end else begin : g_link
      assign next_valid = valid_q[i+1];
      assign next_word  = word_q[i+1];
    end

    fqs_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl),
      .prev_valid (prev_valid),
      .next_valid (next_valid),
      .next_word  (next_word),
      .word_in    (word_in),
      .valid      (valid_q[i]),
      .word       (word_q[i]),
      .match      (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  assign out_ext = {{ITEM_BITS{1'b0}}, data};
  assign occ_ext = {{OCC_BITS{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.data_out  <= out_ext[ITEM_BITS-1:0];
      rsp.found     <= hit;
      rsp.status    <= status;
      rsp.is_empty  <= (count_next == '0);
      rsp.is_full   <= (count_next == CW'(DEPTH));
      rsp.occupancy <= occ_ext[OCC_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fqs_cell.sv */
// ------------------------------------------------------------------------
// FIFO queue with search - storage cell
// One queue slot: shifts toward the head on dequeue, loads on enqueue when
// it is the first empty slot, compares its word against the search word.
// ------------------------------------------------------------------------
`default_nettype none

module fqs_cell import fqs_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_ctl_t            ctl,
  input  wire logic                 prev_valid,
  input  wire logic                 next_valid,
  input  wire logic [WORD_BITS-1:0] next_word,
  input  wire logic [WORD_BITS-1:0] word_in,
  output logic                      valid,
  output logic [WORD_BITS-1:0]      word,
  output logic                      match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.deq) begin
      valid <= next_valid;
    end else if (ctl.enq && !valid && prev_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.deq) begin
      word <= next_word;
    end else if (ctl.enq && !valid && prev_valid) begin
      word <= word_in;
    end
  end

  assign match = valid && (word == word_in);

endmodule

`default_nettype wire

/* hw/rtl/fqs_checker.sv */
// ------------------------------------------------------------------------
// FIFO queue with search - port checker
// Checks result consistency and output hold on the top-level ports.
// ------------------------------------------------------------------------
`default_nettype none

`include "fifo_queue_with_search_macros.svh"

module fqs_checker import fqs_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_ready,
  input wire logic [ITEM_BITS-1:0]   data_out,
  input wire logic                   found,
  input wire logic [STATUS_BITS-1:0] status,
  input wire logic                   is_empty,
  input wire logic                   is_full,
  input wire logic [OCC_BITS-1:0]    occupancy
);

  `FQS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(data_out) && $stable(status))
  `FQS_ASSERT_NOW(a_flags_excl, rsp_valid, !(is_empty && is_full))
  `FQS_ASSERT_NOW(a_empty_occ, rsp_valid && is_empty, occupancy == '0)
  `FQS_ASSERT_NOW(a_full_status, rsp_valid && status == ST_FULL, is_full && !found && data_out == '0)
  `FQS_ASSERT_NOW(a_empty_status, rsp_valid && status == ST_EMPTY, is_empty && data_out == '0)

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .data_out  (rsp.data_out),
  .found     (rsp.found),
  .status    (rsp.status),
  .is_empty  (rsp.is_empty),
  .is_full   (rsp.is_full),
  .occupancy (rsp.occupancy)
);

`default_nettype wire
